[rtl/core/pps_pkg.sv]
// Shared types and constants of the preemptive priority scheduler core.
`timescale 1ns / 1ps

package pps_pkg;

	// Fixed field widths.
	localparam int TIME_W = 21;
	localparam int PID_W  = 8;
	localparam int ARR_W  = 16;
	localparam int BUR_W  = 16;
	localparam int PRI_W  = 8;

	// Marker for "no previous unit": top bit set, never equal to a real pid.
	localparam logic [PID_W:0] NO_PREV = {1'b1, {PID_W{1'b0}}};

	// Input item kinds.
	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_STEP  = 2'd2
	} kind_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_TURN,
		ST_WAIT
	} state_t;

	// One process table entry as it sits in the table memory.
	typedef struct packed {
		logic [PID_W-1:0] pid;
		logic [ARR_W-1:0] arrival;
		logic [BUR_W-1:0] burst;
		logic [PRI_W-1:0] prio;
		logic [BUR_W-1:0] remaining;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Running best candidate and earliest pending arrival during a scan.
	typedef struct packed {
		logic             have_best;
		logic [PRI_W-1:0] best_prio;
		logic [PID_W-1:0] best_pid;
		logic             have_min;
		logic [ARR_W-1:0] min_arr;
	} pick_t;

	// Decision of the entry evaluator for one entry.
	typedef struct packed {
		logic take_best;
		logic take_min;
	} evl_t;

	// One result item.
	typedef struct packed {
		logic              ran;
		logic [PID_W-1:0]  run_pid;
		logic [TIME_W-1:0] slot_time;
		logic              new_segment;
		logic              finished;
		logic [TIME_W-1:0] finish_time;
		logic [TIME_W-1:0] turnaround_time;
		logic [TIME_W-1:0] wait_time;
		logic              all_done;
		logic              load_error;
	} res_t;

endpackage

[rtl/core/pps_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module pps_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/pps_eval.sv]
// Entry evaluator: compares one table entry against the running scan result.
`timescale 1ns / 1ps

module pps_eval (
	input  pps_pkg::entry_t                  ent,
	input  logic [pps_pkg::TIME_W-1:0]       now,
	input  pps_pkg::pick_t                   pick,
	output pps_pkg::evl_t                    evl
);
	import pps_pkg::*;

	logic pending;
	logic arrived;
	logic better;

	// An entry is pending while it has service left, eligible once it has arrived.
	assign pending = (ent.remaining != '0);
	assign arrived = (TIME_W'(ent.arrival) <= now);

	// Lower priority value wins; on a tie the lower pid wins; full ties keep the earlier entry.
	assign better = (ent.prio < pick.best_prio) ||
		((ent.prio == pick.best_prio) && (ent.pid < pick.best_pid));

	always_comb begin
		evl.take_best = pending && arrived && (!pick.have_best || better);
		evl.take_min  = pending && (!pick.have_min || (ent.arrival < pick.min_arr));
	end

endmodule

[rtl/core/preemptive_priority_scheduler_core.sv]
// Top level of the preemptive priority scheduler core: sequencer, counters and result register.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------------
//  input    | start / busy        | kind, pid, arrival, burst, priority_req
//  result   | done (one cycle)    | ran, run_pid, slot_time, new_segment, finished,
//           |                     | finish_time, turnaround_time, wait_time,
//           |                     | all_done, load_error
//
// A clear, a load, an item of unused kind, or a step with nothing left to run gives
// its result in the cycle after the transfer, and the core is ready again at once.
// A step over N loaded entries reads the table memory one entry a cycle through its
// single read port; the result follows the scan and the finish state, and, when the
// chosen process completes, the turnaround and waiting states that form those times.
// Reset clears the counters, time and the previous pid; the table holds no reset value.
// Results are not held: done marks each one for exactly one cycle.
`timescale 1ns / 1ps

module preemptive_priority_scheduler_core #(
	parameter int MAX_PROCS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      kind,
	input  logic [pps_pkg::PID_W-1:0]       pid,
	input  logic [pps_pkg::ARR_W-1:0]       arrival,
	input  logic [pps_pkg::BUR_W-1:0]       burst,
	input  logic [pps_pkg::PRI_W-1:0]       priority_req,
	output logic                            done,
	output logic                            ran,
	output logic [pps_pkg::PID_W-1:0]       run_pid,
	output logic [pps_pkg::TIME_W-1:0]      slot_time,
	output logic                            new_segment,
	output logic                            finished,
	output logic [pps_pkg::TIME_W-1:0]      finish_time,
	output logic [pps_pkg::TIME_W-1:0]      turnaround_time,
	output logic [pps_pkg::TIME_W-1:0]      wait_time,
	output logic                            all_done,
	output logic                            load_error
);
	import pps_pkg::*;

	localparam int IDX_W = $clog2(MAX_PROCS);
	localparam int CNT_W = $clog2(MAX_PROCS + 1);

	// Control state.
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  entry_count_q;
	logic [CNT_W-1:0]  done_count_q;
	logic [TIME_W-1:0] now_q;
	logic [PID_W:0]    prev_pid_q;
	logic [CNT_W-1:0]  issue_idx_q;
	logic              valid_s1;
	logic              have_best_q;
	logic              have_min_q;
	logic              done_q;

	// Payload registers.
	logic [IDX_W-1:0]  idx_s1;
	logic [IDX_W-1:0]  best_idx_q;
	entry_t            best_e_q;
	logic [ARR_W-1:0]  min_arr_q;
	res_t              res_q;

	// Datapath signals.
	kind_t             kind_c;
	logic              accept;
	logic              step_go;
	logic              table_full;
	logic              load_ok;
	logic              last_unit;
	logic              idle_jump;
	logic [TIME_W-1:0] now_inc;
	logic              rd_en;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_ent;
	entry_t            load_ent;
	logic [ENTRY_W-1:0] rd_data;
	entry_t            rd_ent;
	pick_t             pick;
	evl_t              evl;

	// Item decode.
	assign kind_c     = kind_t'(kind);
	assign accept     = start && !busy;
	assign table_full = (entry_count_q >= CNT_W'(MAX_PROCS));
	assign step_go    = accept && (kind_c == KIND_STEP) && (done_count_q != entry_count_q);
	assign load_ok    = accept && (kind_c == KIND_LOAD) && !table_full;
	assign last_unit  = (best_e_q.remaining == BUR_W'(1));
	assign idle_jump  = have_min_q && (TIME_W'(min_arr_q) > now_q);
	assign now_inc    = now_q + TIME_W'(1);

	always_comb begin
		load_ent.pid       = pid;
		load_ent.arrival   = arrival;
		load_ent.burst     = burst;
		load_ent.prio      = priority_req;
		load_ent.remaining = burst;
	end

	// Process table memory.
	pps_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_PROCS)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_ent),
		.re    (rd_en),
		.raddr (issue_idx_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	assign rd_ent = entry_t'(rd_data);

	// Shared entry evaluator.
	always_comb begin
		pick.have_best = have_best_q;
		pick.best_prio = best_e_q.prio;
		pick.best_pid  = best_e_q.pid;
		pick.have_min  = have_min_q;
		pick.min_arr   = min_arr_q;
	end

	pps_eval u_eval (
		.ent  (rd_ent),
		.now  (now_q),
		.pick (pick),
		.evl  (evl)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (step_go) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if ((issue_idx_q == entry_count_q) && !valid_s1) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (have_best_q && last_unit) begin
					state_d = ST_TURN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_TURN: begin
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs: handshake, table reads and table writes.
	always_comb begin
		busy    = 1'b1;
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		wr_addr = entry_count_q[IDX_W-1:0];
		wr_ent  = load_ent;
		case (state_q)
			ST_IDLE: begin
				busy  = 1'b0;
				wr_en = load_ok;
			end
			ST_SCAN: begin
				rd_en = (issue_idx_q != entry_count_q);
			end
			ST_FINISH: begin
				wr_en            = have_best_q;
				wr_addr          = best_idx_q;
				wr_ent           = best_e_q;
				wr_ent.remaining = best_e_q.remaining - BUR_W'(1);
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			entry_count_q <= '0;
			done_count_q  <= '0;
			now_q         <= '0;
			prev_pid_q    <= NO_PREV;
			issue_idx_q   <= '0;
			valid_s1      <= 1'b0;
			have_best_q   <= 1'b0;
			have_min_q    <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= rd_en;
			done_q   <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						done_q <= !step_go;
						case (kind_c)
							KIND_CLEAR: begin
								entry_count_q <= '0;
								done_count_q  <= '0;
								now_q         <= '0;
								prev_pid_q    <= NO_PREV;
							end
							KIND_LOAD: begin
								if (!table_full) begin
									entry_count_q <= entry_count_q + CNT_W'(1);
									if (burst == '0) begin
										done_count_q <= done_count_q + CNT_W'(1);
									end
								end
							end
							KIND_STEP: begin
								issue_idx_q <= '0;
								have_best_q <= 1'b0;
								have_min_q  <= 1'b0;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						issue_idx_q <= issue_idx_q + CNT_W'(1);
					end
					if (valid_s1 && evl.take_best) begin
						have_best_q <= 1'b1;
					end
					if (valid_s1 && evl.take_min) begin
						have_min_q <= 1'b1;
					end
				end
				ST_FINISH: begin
					if (have_best_q) begin
						now_q      <= now_inc;
						prev_pid_q <= {1'b0, best_e_q.pid};
						if (last_unit) begin
							done_count_q <= done_count_q + CNT_W'(1);
						end else begin
							done_q <= 1'b1;
						end
					end else begin
						if (idle_jump) begin
							now_q <= TIME_W'(min_arr_q);
						end
						done_q <= 1'b1;
					end
				end
				ST_WAIT: begin
					done_q <= 1'b1;
				end
				default: begin
					done_q <= 1'b0;
				end
			endcase
		end
	end

	// Scan candidates and the result register.
	always_ff @(posedge clk) begin
		idx_s1 <= issue_idx_q[IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept && !step_go) begin
					res_q <= '0;
					case (kind_c)
						KIND_CLEAR: begin
							res_q.all_done <= 1'b1;
						end
						KIND_LOAD: begin
							if (table_full) begin
								res_q.load_error <= 1'b1;
								res_q.all_done   <= (done_count_q == entry_count_q);
							end else begin
								res_q.all_done <=
									((done_count_q + CNT_W'(burst == '0)) ==
									 (entry_count_q + CNT_W'(1)));
							end
						end
						KIND_STEP: begin
							res_q.slot_time <= now_q;
							res_q.all_done  <= 1'b1;
						end
						default: begin
							res_q.all_done <= (done_count_q == entry_count_q);
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (valid_s1 && evl.take_best) begin
					best_e_q   <= rd_ent;
					best_idx_q <= idx_s1;
				end
				if (valid_s1 && evl.take_min) begin
					min_arr_q <= rd_ent.arrival;
				end
			end
			ST_FINISH: begin
				res_q <= '0;
				if (have_best_q) begin
					res_q.ran         <= 1'b1;
					res_q.run_pid     <= best_e_q.pid;
					res_q.slot_time   <= now_q;
					res_q.new_segment <= (prev_pid_q != {1'b0, best_e_q.pid});
					if (last_unit) begin
						res_q.finished    <= 1'b1;
						res_q.finish_time <= now_inc;
						res_q.all_done <= ((done_count_q + CNT_W'(1)) == entry_count_q);
					end else begin
						res_q.all_done <= (done_count_q == entry_count_q);
					end
				end else begin
					res_q.slot_time <= idle_jump ? TIME_W'(min_arr_q) : now_q;
					res_q.all_done  <= (done_count_q == entry_count_q);
				end
			end
			ST_TURN: begin
				res_q.turnaround_time <= res_q.finish_time - TIME_W'(best_e_q.arrival);
			end
			ST_WAIT: begin
				res_q.wait_time <= res_q.turnaround_time - TIME_W'(best_e_q.burst);
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	// Result ports.
	assign done            = done_q;
	assign ran             = res_q.ran;
	assign run_pid         = res_q.run_pid;
	assign slot_time       = res_q.slot_time;
	assign new_segment     = res_q.new_segment;
	assign finished        = res_q.finished;
	assign finish_time     = res_q.finish_time;
	assign turnaround_time = res_q.turnaround_time;
	assign wait_time       = res_q.wait_time;
	assign all_done        = res_q.all_done;
	assign load_error      = res_q.load_error;

	// The completed count never passes the loaded count.
	a_done_le_entry: assert property (@(posedge clk) disable iff (!arst_n)
		done_count_q <= entry_count_q)
		else $error("done count exceeds entry count");

	// The table never holds more entries than it has room for.
	a_entry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CNT_W'(MAX_PROCS))
		else $error("entry count beyond table size");

	// A result transfer only happens once the sequencer is back at rest.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe while sequencer busy");

	// A completion is always reported together with the unit that ran.
	a_fin_ran: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.finished) |-> res_q.ran)
		else $error("finished without a run");

	// The scan only ends after the last table read has been evaluated.
	a_scan_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> !valid_s1)
		else $error("scan ended with a read in flight");

endmodule

[tb/tb_preemptive_priority_scheduler_core.sv]
// Self-checking testbench for the preemptive priority scheduler core: directed table, then random batches.
`timescale 1ns / 1ps

module tb_preemptive_priority_scheduler_core;
	import pps_pkg::*;

	localparam int         MAX_PROCS   = 16;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int         ITEM_TARGET = 550;
	localparam int         QUIET_FIRST = 250;
	localparam int         QUIET_LAST  = 350;
	localparam int         CYCLE_LIMIT = 200000;
	localparam int         STEP_CAP    = 60;

	// One row of the directed stimulus; the expected result is typed in when fixed is set.
	typedef struct packed {
		logic [1:0]        op;
		logic [PID_W-1:0]  id;
		logic [ARR_W-1:0]  arr;
		logic [BUR_W-1:0]  len;
		logic [PRI_W-1:0]  prio;
		logic              fixed;
		logic [TIME_W-1:0] slot;
		logic              all_fin;
		logic              err;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [1:0]          kind = '0;
	logic [PID_W-1:0]    pid = '0;
	logic [ARR_W-1:0]    arrival = '0;
	logic [BUR_W-1:0]    burst = '0;
	logic [PRI_W-1:0]    priority_req = '0;
	logic                done;
	logic                ran;
	logic [PID_W-1:0]    run_pid;
	logic [TIME_W-1:0]   slot_time;
	logic                new_segment;
	logic                finished;
	logic [TIME_W-1:0]   finish_time;
	logic [TIME_W-1:0]   turnaround_time;
	logic [TIME_W-1:0]   wait_time;
	logic                all_done;
	logic                load_error;

	// Process table and scheduler state as the testbench sees it.
	logic [PID_W-1:0]    tbl_pid   [MAX_PROCS];
	logic [ARR_W-1:0]    tbl_arr   [MAX_PROCS];
	logic [BUR_W-1:0]    tbl_burst [MAX_PROCS];
	logic [PRI_W-1:0]    tbl_prio  [MAX_PROCS];
	logic [BUR_W-1:0]    tbl_left  [MAX_PROCS];
	int                  loaded_cnt = 0;
	int                  finished_cnt = 0;
	logic [TIME_W-1:0]   sched_now = '0;
	logic [PID_W:0]      prev_unit_pid = NO_PREV;

	res_t                expected_results[$];
	stim_row_t           directed_rows[$];

	int                  error_count = 0;
	int                  results_checked = 0;
	int                  cycle_count = 0;
	int                  useful_items = 0;
	int                  clears_sent = 0;
	int                  loads_sent = 0;
	int                  steps_sent = 0;
	int                  ignored_items = 0;
	int                  completions = 0;
	int                  idle_jumps = 0;
	int                  full_loads = 0;

	preemptive_priority_scheduler_core #(.MAX_PROCS(MAX_PROCS)) DUT (.*);

	// Free-running clock, 20 ns period.
	always #10 clk = ~clk;

	// Work out the result of one item and advance the scheduler state.
	function automatic res_t predict_decision(logic [1:0] op, logic [PID_W-1:0] id,
		logic [ARR_W-1:0] arr, logic [BUR_W-1:0] len, logic [PRI_W-1:0] prio);
		res_t              r;
		int                best;
		int                i;
		logic              any_left;
		logic [TIME_W-1:0] earliest;
		logic [TIME_W-1:0] ta;
		r = '0;
		best = -1;
		any_left = 1'b0;
		earliest = '0;
		case (op)
			KIND_CLEAR: begin
				loaded_cnt = 0;
				finished_cnt = 0;
				sched_now = '0;
				prev_unit_pid = NO_PREV;
			end
			KIND_LOAD: begin
				if (loaded_cnt >= MAX_PROCS) begin
					r.load_error = 1'b1;
					full_loads++;
				end else begin
					tbl_pid[loaded_cnt] = id;
					tbl_arr[loaded_cnt] = arr;
					tbl_burst[loaded_cnt] = len;
					tbl_prio[loaded_cnt] = prio;
					tbl_left[loaded_cnt] = len;
					if (len == '0)
						finished_cnt++;
					loaded_cnt++;
				end
			end
			KIND_STEP: begin
				if (finished_cnt < loaded_cnt) begin
					// Best arrived entry: lowest priority value, then lowest pid, then lowest index.
					for (i = 0; i < loaded_cnt; i++) begin
						if (tbl_left[i] != '0 && tbl_arr[i] <= sched_now) begin
							if (best < 0 || tbl_prio[i] < tbl_prio[best] ||
								(tbl_prio[i] == tbl_prio[best] && tbl_pid[i] < tbl_pid[best]))
								best = i;
						end
					end
					if (best >= 0) begin
						r.ran = 1'b1;
						r.run_pid = tbl_pid[best];
						r.slot_time = sched_now;
						r.new_segment = (prev_unit_pid != {1'b0, tbl_pid[best]});
						tbl_left[best] = tbl_left[best] - 1'b1;
						sched_now = sched_now + 1'b1;
						prev_unit_pid = {1'b0, tbl_pid[best]};
						if (tbl_left[best] == '0) begin
							ta = sched_now - tbl_arr[best];
							finished_cnt++;
							completions++;
							r.finished = 1'b1;
							r.finish_time = sched_now;
							r.turnaround_time = ta;
							r.wait_time = ta - tbl_burst[best];
						end
					end else begin
						// Nothing has arrived: jump to the earliest pending arrival.
						for (i = 0; i < loaded_cnt; i++) begin
							if (tbl_left[i] != '0 && (!any_left || tbl_arr[i] < earliest)) begin
								earliest = TIME_W'(tbl_arr[i]);
								any_left = 1'b1;
							end
						end
						if (any_left && earliest > sched_now) begin
							sched_now = earliest;
							idle_jumps++;
						end
						r.slot_time = sched_now;
					end
				end else begin
					r.slot_time = sched_now;
				end
			end
			default: ;
		endcase
		r.all_done = (finished_cnt == loaded_cnt);
		return r;
	endfunction

	// Present one item, hold it until the transfer, then queue its expected result.
	task automatic issue(logic [1:0] op, logic [PID_W-1:0] id, logic [ARR_W-1:0] arr,
		logic [BUR_W-1:0] len, logic [PRI_W-1:0] prio, logic fixed, res_t fixed_res);
		res_t predicted;
		start <= 1'b1;
		kind <= op;
		pid <= id;
		arrival <= arr;
		burst <= len;
		priority_req <= prio;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		predicted = predict_decision(op, id, arr, len, prio);
		expected_results.push_back(fixed ? fixed_res : predicted);
		case (op)
			KIND_CLEAR: clears_sent++;
			KIND_LOAD:  loads_sent++;
			KIND_STEP:  steps_sent++;
			default:    ignored_items++;
		endcase
		if (op != KIND_UNUSED)
			useful_items++;
	endtask

	// Occasional random sender gap, outside the quiet window, with noise on the payload while start is low.
	task automatic maybe_idle();
		int gap;
		if (useful_items >= QUIET_FIRST && useful_items < QUIET_LAST)
			return;
		if ($urandom_range(99) < 34) begin
			gap = ($urandom_range(3) == 0) ? $urandom_range(24, 4) : $urandom_range(3, 1);
			start <= 1'b0;
			kind <= 2'($urandom);
			pid <= PID_W'($urandom);
			arrival <= ARR_W'($urandom);
			burst <= BUR_W'($urandom);
			priority_req <= PRI_W'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending until every expected result has come back.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Send one item of the given kind with a random payload.
	task automatic issue_noise(logic [1:0] op);
		issue(op, PID_W'($urandom), ARR_W'($urandom), BUR_W'($urandom), PRI_W'($urandom),
			1'b0, '0);
	endtask

	// Load one process with mostly small, clashing values and now and then full-range ones.
	task automatic load_random_process();
		logic [PID_W-1:0] id;
		logic [ARR_W-1:0] arr;
		logic [BUR_W-1:0] len;
		logic [PRI_W-1:0] prio;
		int               roll;
		id = PID_W'(($urandom_range(99) < 70) ? $urandom_range(7) : $urandom);
		roll = $urandom_range(99);
		arr = ARR_W'((roll < 75) ? $urandom_range(12) : (roll < 90) ? $urandom_range(40) : $urandom);
		roll = $urandom_range(99);
		len = BUR_W'((roll < 10) ? 0 : (roll < 85) ? $urandom_range(5, 1) :
			(roll < 95) ? $urandom_range(12, 6) : $urandom);
		prio = PRI_W'(($urandom_range(99) < 60) ? $urandom_range(3) : $urandom);
		issue(KIND_LOAD, id, arr, len, prio, 1'b0, '0);
	endtask

	task automatic add_row(logic [1:0] op, int id, int arr, int len, int prio,
		logic fixed, int slot, logic all_fin, logic err);
		stim_row_t row;
		row.op = op;
		row.id = PID_W'(id);
		row.arr = ARR_W'(arr);
		row.len = BUR_W'(len);
		row.prio = PRI_W'(prio);
		row.fixed = fixed;
		row.slot = TIME_W'(slot);
		row.all_fin = all_fin;
		row.err = err;
		directed_rows.push_back(row);
	endtask

	// Compare one field of a result against its expectation.
	task automatic compare_field(string field, logic [31:0] want_v, logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
			error_count++;
		end
	endtask

	// Every strobed result is matched against the oldest expectation.
	always @(posedge clk) begin : result_check
		res_t want;
		if (done === 1'b1) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with no expectation waiting, actual run_pid %0d slot_time %0d",
					$time, run_pid, slot_time);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				compare_field("ran", 32'(want.ran), 32'(ran));
				compare_field("run_pid", 32'(want.run_pid), 32'(run_pid));
				compare_field("slot_time", 32'(want.slot_time), 32'(slot_time));
				compare_field("new_segment", 32'(want.new_segment), 32'(new_segment));
				compare_field("finished", 32'(want.finished), 32'(finished));
				compare_field("finish_time", 32'(want.finish_time), 32'(finish_time));
				compare_field("turnaround_time", 32'(want.turnaround_time),
					32'(turnaround_time));
				compare_field("wait_time", 32'(want.wait_time), 32'(wait_time));
				compare_field("all_done", 32'(want.all_done), 32'(all_done));
				compare_field("load_error", 32'(want.load_error), 32'(load_error));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding.",
				cycle_count, expected_results.size());
			$display("tb_preemptive_priority_scheduler_core: FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		stim_row_t row;
		res_t      fixed_res;
		int        roll;
		int        n_loads;
		int        steps;

		// Empty table, unused kind, idle jump, late load, then a full table with ties.
		add_row(KIND_STEP,   0,     0,     0,   0, 1,     0, 1, 0);
		add_row(KIND_UNUSED, 0,     0,     0,   0, 1,     0, 1, 0);
		add_row(KIND_LOAD, 255, 65535,     2, 255, 1,     0, 0, 0);
		add_row(KIND_STEP,   0,     0,     0,   0, 1, 65535, 0, 0);
		add_row(KIND_STEP,   0,     0,     0,   0, 0,     0, 0, 0);
		add_row(KIND_LOAD,   7,     0,     1,   0, 1,     0, 0, 0);
		add_row(KIND_STEP,   0,     0,     0,   0, 0,     0, 0, 0);
		add_row(KIND_STEP,   0,     0,     0,   0, 0,     0, 0, 0);
		add_row(KIND_STEP,   0,     0,     0,   0, 0,     0, 0, 0);
		add_row(KIND_CLEAR,  0,     0,     0,   0, 1,     0, 1, 0);
		add_row(KIND_LOAD,   0,     0,     0,   0, 1,     0, 1, 0);
		add_row(KIND_LOAD,   9,     0,     2,   5, 1,     0, 0, 0);
		add_row(KIND_LOAD,   4,     0,     1,   5, 1,     0, 0, 0);
		add_row(KIND_LOAD,   4,     0,     1,   5, 1,     0, 0, 0);
		add_row(KIND_LOAD, 128,     1, 65535, 254, 1,     0, 0, 0);
		add_row(KIND_LOAD,   3,     2,     1,   0, 1,     0, 0, 0);
		add_row(KIND_LOAD, 200,    30,     1,   1, 1,     0, 0, 0);
		add_row(KIND_LOAD,  17,     3,     3,   9, 1,     0, 0, 0);
		add_row(KIND_LOAD, 255,     0,     1,   5, 1,     0, 0, 0);
		add_row(KIND_LOAD,  60,     4,     2, 128, 1,     0, 0, 0);
		add_row(KIND_LOAD,  61,     4,     2, 128, 1,     0, 0, 0);
		add_row(KIND_LOAD,  12,   100,     1,   0, 1,     0, 0, 0);
		add_row(KIND_LOAD,  99,     7,     1,   3, 1,     0, 0, 0);
		add_row(KIND_LOAD,  33,     0,     4,   7, 1,     0, 0, 0);
		add_row(KIND_LOAD, 250,    20,     2, 200, 1,     0, 0, 0);
		add_row(KIND_LOAD,   5,    50,     1,   2, 1,     0, 0, 0);
		add_row(KIND_LOAD,   1,     0,     1,   0, 1,     0, 0, 1);
		add_row(KIND_STEP,   0,     0,     0,   0, 0,     0, 0, 0);
		add_row(KIND_STEP,   0,     0,     0,   0, 0,     0, 0, 0);

		// Reset once at the start.
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			fixed_res = '0;
			fixed_res.slot_time = row.slot;
			fixed_res.all_done = row.all_fin;
			fixed_res.load_error = row.err;
			maybe_idle();
			issue(row.op, row.id, row.arr, row.len, row.prio, row.fixed, fixed_res);
		end
		drain_results();

		// Random batches: clear, load a table, then step it toward completion, up to a cap, with some noise.
		while (useful_items < ITEM_TARGET) begin
			if ($urandom_range(9) == 0)
				drain_results();
			maybe_idle();
			issue_noise(KIND_CLEAR);
			roll = $urandom_range(99);
			n_loads = (roll < 80) ? $urandom_range(6, 1) :
				(roll < 95) ? $urandom_range(15, 7) : $urandom_range(18, 16);
			repeat (n_loads) begin
				maybe_idle();
				load_random_process();
			end
			steps = 0;
			while (finished_cnt != loaded_cnt && steps < STEP_CAP) begin
				maybe_idle();
				roll = $urandom_range(99);
				if (roll < 6)
					load_random_process();
				else if (roll < 9)
					issue_noise(KIND_UNUSED);
				else if (roll < 10)
					issue_noise(KIND_CLEAR);
				else
					issue_noise(KIND_STEP);
				steps++;
			end
			// Now and then a step once everything has finished.
			if ($urandom_range(3) == 0) begin
				maybe_idle();
				issue_noise(KIND_STEP);
			end
		end

		// Let the last results come back, then allow for the longest scan.
		drain_results();
		repeat (40) @(posedge clk);

		$display("Sent %0d clears, %0d loads (%0d into a full table), %0d steps, %0d unused kinds.",
			clears_sent, loads_sent, full_loads, steps_sent, ignored_items);
		$display("Checked %0d results: %0d completions, %0d idle jumps, %0d mismatches.",
			results_checked, completions, idle_jumps, error_count);
		if (error_count == 0)
			$display("tb_preemptive_priority_scheduler_core: PASS");
		else
			$display("tb_preemptive_priority_scheduler_core: FAIL");
		$finish;
	end

endmodule

[sim.f]
rtl/core/pps_pkg.sv
rtl/core/pps_ram.sv
rtl/core/pps_eval.sv
rtl/core/preemptive_priority_scheduler_core.sv
tb/tb_preemptive_priority_scheduler_core.sv
